// ===== hw/rtl/pbfb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and beat types for the parallel biquad filter bank.
package pbfb_pkg;

  localparam int SECTIONS   = 16;
  localparam int COEF_DEPTH = 5 * SECTIONS;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);
  localparam int HIST_AW    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int Y_W      = 32;
  localparam int HIST_W   = 2 * Y_W;
  localparam int PROD_W   = 64;
  localparam int ACC_W    = 64;
  localparam int RND_SH   = 20;
  localparam int RND_W    = ACC_W - RND_SH;
  localparam int TOTAL_W  = Y_W + $clog2(SECTIONS + 1) + 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 32;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_COEF   = 1'b1;

  localparam logic [2:0] SEL_B0 = 3'd0;
  localparam logic [2:0] SEL_B1 = 3'd1;
  localparam logic [2:0] SEL_B2 = 3'd2;
  localparam logic [2:0] SEL_A1 = 3'd3;
  localparam logic [2:0] SEL_A2 = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECT_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_ENABLE = 1'b1;

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic [3:0]                 section_index;
    logic [2:0]                 coefficient_select;
    logic signed [COEF_W-1:0]   coefficient_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mono_out;
    logic                       saturated;
  } out_item_t;

  // One multiply issued by the sequencer.
  typedef struct packed {
    logic               vld;
    logic               direct;
    logic [2:0]         k;
    logic               last;
    logic               final_term;
    logic [HIST_AW-1:0] sec;
  } issue_t;

  typedef struct packed {
    logic               we;
    logic [COEF_AW-1:0] addr;
    logic [COEF_W-1:0]  data;
  } coef_wr_t;

  typedef struct packed {
    logic               re;
    logic [COEF_AW-1:0] addr;
  } coef_rd_t;

  typedef struct packed {
    logic               we;
    logic [HIST_AW-1:0] addr;
    logic [HIST_W-1:0]  data;
  } hist_wr_t;

  typedef struct packed {
    logic               re;
    logic [HIST_AW-1:0] addr;
  } hist_rd_t;

endpackage

// ===== hw/rtl/pbfb_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module pbfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/pbfb_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: clear sweep, coefficient writes and per-sample multiply issue.
module pbfb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  pbfb_pkg::in_item_t  in_data,
  input  logic                bank_enable,
  input  logic                out_free,
  input  logic                mac_done,
  output logic                in_ready,
  output logic                load_out,
  output pbfb_pkg::coef_wr_t  coef_wr,
  output pbfb_pkg::coef_rd_t  coef_rd,
  output pbfb_pkg::hist_rd_t  hist_rd,
  output pbfb_pkg::hist_wr_t  clr_wr,
  output pbfb_pkg::issue_t    issue
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_RUN    = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  localparam int WA_W = pbfb_pkg::COEF_AW + 3;
  localparam logic [pbfb_pkg::HIST_AW-1:0] SEC_LAST =
    pbfb_pkg::HIST_AW'(pbfb_pkg::SECTIONS - 1);

  state_t                        state;
  logic [pbfb_pkg::COEF_AW-1:0]  clr_cnt;
  logic                          dir_pend;
  logic [pbfb_pkg::COEF_AW-1:0]  coef_addr;
  logic [2:0]                    k;
  logic [pbfb_pkg::HIST_AW-1:0]  sec;

  logic            in_fire;
  logic            start_run;
  logic            wr_ok;
  logic [WA_W-1:0] sec_w;
  logic [WA_W-1:0] waddr_w;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign start_run = (in_data.action == pbfb_pkg::ACT_SAMPLE) && bank_enable;
  assign load_out  = (state == ST_FINISH) && out_free;

  // Coefficient entry is 5*section + select; drop writes outside the table.
  assign wr_ok   = (32'(in_data.section_index) < 32'(pbfb_pkg::SECTIONS))
                && (in_data.coefficient_select <= pbfb_pkg::SEL_A2);
  assign sec_w   = WA_W'(in_data.section_index);
  assign waddr_w = (sec_w << 2) + sec_w + WA_W'(in_data.coefficient_select);

  always_comb begin
    coef_wr = '0;
    if (state == ST_CLEAR) begin
      coef_wr.we   = 1'b1;
      coef_wr.addr = clr_cnt;
      coef_wr.data = '0;
    end else if (in_fire && (in_data.action == pbfb_pkg::ACT_COEF) && wr_ok) begin
      coef_wr.we   = 1'b1;
      coef_wr.addr = waddr_w[pbfb_pkg::COEF_AW-1:0];
      coef_wr.data = in_data.coefficient_value;
    end
  end

  always_comb begin
    clr_wr      = '0;
    clr_wr.we   = (state == ST_CLEAR)
               && ({1'b0, clr_cnt} < (pbfb_pkg::COEF_AW + 1)'(pbfb_pkg::SECTIONS));
    clr_wr.addr = clr_cnt[pbfb_pkg::HIST_AW-1:0];
  end

  always_comb begin
    coef_rd.re   = (state == ST_RUN) && !dir_pend;
    coef_rd.addr = coef_addr;
    hist_rd.re   = (state == ST_RUN) && !dir_pend && (k == pbfb_pkg::SEL_B0);
    hist_rd.addr = sec;

    issue.vld        = (state == ST_RUN);
    issue.direct     = dir_pend;
    issue.k          = k;
    issue.last       = dir_pend || (k == pbfb_pkg::SEL_A2);
    issue.final_term = !dir_pend && (k == pbfb_pkg::SEL_A2) && (sec == SEC_LAST);
    issue.sec        = sec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      dir_pend  <= 1'b0;
      coef_addr <= '0;
      k         <= pbfb_pkg::SEL_B0;
      sec       <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (clr_cnt == pbfb_pkg::COEF_AW'(pbfb_pkg::COEF_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
          clr_cnt <= clr_cnt + pbfb_pkg::COEF_AW'(1);
        end
        ST_IDLE: begin
          if (in_fire && start_run) begin
            state     <= ST_RUN;
            dir_pend  <= 1'b1;
            coef_addr <= '0;
            k         <= pbfb_pkg::SEL_B0;
            sec       <= '0;
          end
        end
        ST_RUN: begin
          if (dir_pend) begin
            dir_pend <= 1'b0;
          end else begin
            coef_addr <= coef_addr + pbfb_pkg::COEF_AW'(1);
            if (k == pbfb_pkg::SEL_A2) begin
              k   <= pbfb_pkg::SEL_B0;
              sec <= sec + pbfb_pkg::HIST_AW'(1);
              if (sec == SEC_LAST) begin
                state <= ST_DRAIN;
              end
            end else begin
              k <= k + 3'd1;
            end
          end
        end
        ST_DRAIN: begin
          if (mac_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/pbfb_mac.sv =====
`timescale 1ns / 1ps
// Shared multiply-accumulate pipeline: product, term sum, round, clamp, total.
module pbfb_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pbfb_pkg::issue_t                     issue,
  input  logic [pbfb_pkg::COEF_W-1:0]          coef_rdata,
  input  logic [pbfb_pkg::HIST_W-1:0]          hist_rdata,
  input  logic signed [pbfb_pkg::COEF_W-1:0]   direct_gain,
  input  logic signed [pbfb_pkg::SAMPLE_W-1:0] x,
  input  logic signed [pbfb_pkg::SAMPLE_W-1:0] x1,
  input  logic signed [pbfb_pkg::SAMPLE_W-1:0] x2,
  output pbfb_pkg::hist_wr_t                   mac_wr,
  output logic                                 done,
  output logic signed [pbfb_pkg::TOTAL_W-1:0]  total
);

  localparam int Y_W   = pbfb_pkg::Y_W;
  localparam int RND_W = pbfb_pkg::RND_W;
  localparam logic signed [RND_W-1:0] Y_MAX = {{(RND_W-Y_W+1){1'b0}}, {(Y_W-1){1'b1}}};
  localparam logic signed [RND_W-1:0] Y_MIN = {{(RND_W-Y_W+1){1'b1}}, {(Y_W-1){1'b0}}};
  localparam logic signed [pbfb_pkg::ACC_W-1:0] RND_HALF =
    pbfb_pkg::ACC_W'(1) << (pbfb_pkg::RND_SH - 1);

  pbfb_pkg::issue_t ctl_b, ctl_c, ctl_d, ctl_e, ctl_e_next;

  logic signed [pbfb_pkg::COEF_W-1:0] coef_op;
  logic signed [Y_W-1:0]              opnd;
  logic signed [pbfb_pkg::PROD_W-1:0] prod;
  logic signed [pbfb_pkg::PROD_W-1:0] prod_c;
  logic                               neg_c;
  logic [Y_W-1:0]                     y1_hold;

  logic signed [pbfb_pkg::ACC_W-1:0]  term;
  logic signed [pbfb_pkg::ACC_W-1:0]  acc_base;
  logic signed [pbfb_pkg::ACC_W-1:0]  acc;
  logic signed [pbfb_pkg::ACC_W-1:0]  rnd_sum;
  logic signed [RND_W-1:0]            rnd_e;
  logic signed [Y_W-1:0]              y;

  // Operand pick: direct gain runs against x with no table read.
  always_comb begin
    coef_op = ctl_b.direct ? direct_gain : $signed(coef_rdata);
    case (ctl_b.k)
      pbfb_pkg::SEL_B0: opnd = Y_W'(x);
      pbfb_pkg::SEL_B1: opnd = Y_W'(x1);
      pbfb_pkg::SEL_B2: opnd = Y_W'(x2);
      pbfb_pkg::SEL_A1: opnd = $signed(hist_rdata[pbfb_pkg::HIST_W-1:Y_W]);
      pbfb_pkg::SEL_A2: opnd = $signed(hist_rdata[Y_W-1:0]);
      default:          opnd = '0;
    endcase
    if (ctl_b.direct) begin
      opnd = Y_W'(x);
    end
    prod = coef_op * opnd;
  end

  assign term     = prod_c >>> 8;
  assign acc_base = (ctl_c.direct || (ctl_c.k == pbfb_pkg::SEL_B0)) ? '0 : acc;
  assign rnd_sum  = acc + RND_HALF;

  always_comb begin
    if (rnd_e > Y_MAX) begin
      y = Y_MAX[Y_W-1:0];
    end else if (rnd_e < Y_MIN) begin
      y = Y_MIN[Y_W-1:0];
    end else begin
      y = rnd_e[Y_W-1:0];
    end
  end

  // New history row: y becomes y1, old y1 becomes y2.
  always_comb begin
    mac_wr.we   = ctl_e.vld && !ctl_e.direct;
    mac_wr.addr = ctl_e.sec;
    mac_wr.data = {y, y1_hold};
  end

  assign done = ctl_e.vld && ctl_e.final_term;

  // Only the last term of a section moves on to the clamp and total stage.
  always_comb begin
    ctl_e_next     = ctl_d;
    ctl_e_next.vld = ctl_d.vld && ctl_d.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b <= '0;
      ctl_c <= '0;
      ctl_d <= '0;
      ctl_e <= '0;
    end else begin
      ctl_b <= issue;
      ctl_c <= ctl_b;
      ctl_d <= ctl_c;
      ctl_e <= ctl_e_next;
    end
  end

  always_ff @(posedge clk) begin
    prod_c <= prod;
    neg_c  <= !ctl_b.direct
           && ((ctl_b.k == pbfb_pkg::SEL_A1) || (ctl_b.k == pbfb_pkg::SEL_A2));
    if (ctl_b.vld && !ctl_b.direct && (ctl_b.k == pbfb_pkg::SEL_A1)) begin
      y1_hold <= hist_rdata[pbfb_pkg::HIST_W-1:Y_W];
    end
    if (ctl_c.vld) begin
      acc <= neg_c ? (acc_base - term) : (acc_base + term);
    end
    if (ctl_d.vld && ctl_d.last) begin
      rnd_e <= RND_W'(rnd_sum >>> pbfb_pkg::RND_SH);
    end
    if (ctl_e.vld) begin
      total <= ctl_e.direct ? pbfb_pkg::TOTAL_W'(y) : (total + pbfb_pkg::TOTAL_W'(y));
    end
  end

endmodule

// ===== hw/rtl/parallel_biquad_filter_bank_core.sv =====
`timescale 1ns / 1ps
// Top level of the parallel biquad filter bank: config, memories, output beat.
// Sample beat: result valid after the direct term and every section term, one
//   product per cycle through a single shared multiplier fed by one coefficient read.
// The next beat is accepted as the result appears; no new sample is taken before that.
// Coefficient write beat and disabled-bank sample beat: taken without leaving IDLE, no result.
// Reset: synchronous; then a clear sweep zeroes both memories, no beat accepted.
module parallel_biquad_filter_bank_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  pbfb_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output pbfb_pkg::out_item_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [pbfb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pbfb_pkg::CFG_W-1:0]            cfg_data
);

  localparam int TOTAL_W = pbfb_pkg::TOTAL_W;
  localparam int S_W     = pbfb_pkg::SAMPLE_W;
  localparam logic signed [TOTAL_W-1:0] SAT_HI = {{(TOTAL_W-S_W+1){1'b0}}, {(S_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] SAT_LO = {{(TOTAL_W-S_W+1){1'b1}}, {(S_W-1){1'b0}}};

  // Configuration registers.
  logic signed [pbfb_pkg::COEF_W-1:0] direct_gain;
  logic                               bank_enable;

  // Mono input history, shared by every section.
  logic signed [S_W-1:0] x, x1, x2;
  logic signed [S_W:0]   lr_sum;

  logic in_fire;
  logic out_free;
  logic load_out;
  logic mac_done;

  pbfb_pkg::coef_wr_t coef_wr;
  pbfb_pkg::coef_rd_t coef_rd;
  pbfb_pkg::hist_rd_t hist_rd;
  pbfb_pkg::hist_wr_t clr_wr;
  pbfb_pkg::hist_wr_t mac_wr;
  pbfb_pkg::hist_wr_t hist_wr;
  pbfb_pkg::issue_t   issue;

  logic [pbfb_pkg::COEF_W-1:0]      coef_rdata;
  logic [pbfb_pkg::HIST_W-1:0]      hist_rdata;
  logic signed [TOTAL_W-1:0]        total;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Average the stereo pair: 25-bit sum, drop the LSB (floor).
  assign lr_sum = {in_data.left_sample[S_W-1], in_data.left_sample}
                + {in_data.right_sample[S_W-1], in_data.right_sample};

  // The clear sweep and the pipeline never run together; clear wins.
  assign hist_wr = clr_wr.we ? clr_wr : mac_wr;

  pbfb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .bank_enable (bank_enable),
    .out_free    (out_free),
    .mac_done    (mac_done),
    .in_ready    (in_ready),
    .load_out    (load_out),
    .coef_wr     (coef_wr),
    .coef_rd     (coef_rd),
    .hist_rd     (hist_rd),
    .clr_wr      (clr_wr),
    .issue       (issue)
  );

  // Coefficient table: entry 5*section + select.
  pbfb_ram #(
    .WIDTH (pbfb_pkg::COEF_W),
    .DEPTH (pbfb_pkg::COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_wr.we),
    .waddr (coef_wr.addr),
    .wdata (coef_wr.data),
    .re    (coef_rd.re),
    .raddr (coef_rd.addr),
    .rdata (coef_rdata)
  );

  // Section output history: one row {y1, y2} per section, one read and one
  // write per section per sample, so no entry is touched twice in flight.
  pbfb_ram #(
    .WIDTH (pbfb_pkg::HIST_W),
    .DEPTH (pbfb_pkg::SECTIONS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_wr.we),
    .waddr (hist_wr.addr),
    .wdata (hist_wr.data),
    .re    (hist_rd.re),
    .raddr (hist_rd.addr),
    .rdata (hist_rdata)
  );

  pbfb_mac u_mac (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .coef_rdata  (coef_rdata),
    .hist_rdata  (hist_rdata),
    .direct_gain (direct_gain),
    .x           (x),
    .x1          (x1),
    .x2          (x2),
    .mac_wr      (mac_wr),
    .done        (mac_done),
    .total       (total)
  );

  // Configuration writes; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      direct_gain <= '0;
      bank_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pbfb_pkg::REG_DIRECT_GAIN: direct_gain <= $signed(cfg_data);
        pbfb_pkg::REG_BANK_ENABLE: bank_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Latch the mono sample at accept; advance the input history only when the
  // result beat is loaded, so a disabled or pending sample leaves it alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
    end else if (load_out) begin
      x1 <= x;
      x2 <= x1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_data.action == pbfb_pkg::ACT_SAMPLE)) begin
      x <= lr_sum[S_W:1];
    end
  end

  // Output register: hold the beat until taken, clip the total to 24 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (total > SAT_HI) begin
        out_data.mono_out  <= SAT_HI[S_W-1:0];
        out_data.saturated <= 1'b1;
      end else if (total < SAT_LO) begin
        out_data.mono_out  <= SAT_LO[S_W-1:0];
        out_data.saturated <= 1'b1;
      end else begin
        out_data.mono_out  <= total[S_W-1:0];
        out_data.saturated <= 1'b0;
      end
    end
  end

endmodule

// ===== tb/sv/filter_bank_checker.sv =====
`timescale 1ns / 1ps
// Filter bank checker: channel monitor, bit-exact mono predictor and result comparison.
module filter_bank_checker
  import pbfb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  logic signed [COEF_W-1:0]   coef_mem [COEF_DEPTH];
  logic signed [Y_W-1:0]      y_hist [2*SECTIONS];
  logic signed [SAMPLE_W-1:0] x_hist [2];
  logic signed [COEF_W-1:0]   gain;
  logic                       enabled;
  out_item_t                  expected_mono [$];

  // Q4.28 times a 23-fraction-bit value, floored to 43 fraction bits.
  function automatic logic signed [63:0] weigh(logic signed [31:0] c, logic signed [63:0] v);
    logic signed [63:0] p;
    p = c * v;
    return p >>> 8;
  endfunction

  function automatic logic signed [63:0] round_q23(logic signed [63:0] acc);
    return (acc + 64'sd524288) >>> 20;
  endfunction

  // Run one mono sample through the direct path and every section, update histories.
  function automatic out_item_t filter_sample(in_item_t b);
    logic signed [63:0] x, x1, x2, y1, y2, acc, y, total;
    out_item_t r;
    x = $signed(b.left_sample);
    x = x + $signed(b.right_sample);
    x = x >>> 1;
    x1 = x_hist[0];
    x2 = x_hist[1];
    total = round_q23(weigh(gain, x));
    for (int s = 0; s < SECTIONS; s++) begin
      y1 = y_hist[2*s];
      y2 = y_hist[2*s+1];
      acc = weigh(coef_mem[5*s+SEL_B0], x) + weigh(coef_mem[5*s+SEL_B1], x1)
          + weigh(coef_mem[5*s+SEL_B2], x2) - weigh(coef_mem[5*s+SEL_A1], y1)
          - weigh(coef_mem[5*s+SEL_A2], y2);
      y = round_q23(acc);
      if (y > 64'sd2147483647) y = 64'sd2147483647;
      if (y < -64'sd2147483648) y = -64'sd2147483648;
      y_hist[2*s+1] = y1[31:0];
      y_hist[2*s]   = y[31:0];
      total = total + y;
    end
    x_hist[1] = x1[23:0];
    x_hist[0] = x[23:0];
    r.saturated = 1'b0;
    if (total > 64'sd8388607) begin
      total = 64'sd8388607;
      r.saturated = 1'b1;
    end else if (total < -64'sd8388608) begin
      total = -64'sd8388608;
      r.saturated = 1'b1;
    end
    r.mono_out = total[23:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      foreach (coef_mem[i]) coef_mem[i] = '0;
      foreach (y_hist[i]) y_hist[i] = '0;
      x_hist[0] = '0;
      x_hist[1] = '0;
      gain = '0;
      enabled = 1'b0;
      expected_mono.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DIRECT_GAIN: gain = cfg_data;
          REG_BANK_ENABLE: enabled = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.action == ACT_COEF) begin
          if (int'(in_data.section_index) < SECTIONS && in_data.coefficient_select <= SEL_A2)
            coef_mem[5*in_data.section_index + in_data.coefficient_select] =
              in_data.coefficient_value;
        end else if (enabled) begin
          expected_mono = {expected_mono, filter_sample(in_data)};
        end
      end
      if (out_valid && out_ready) begin
        if (expected_mono.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat, expected none, actual mono_out %h saturated %b",
                   $time, out_data.mono_out, out_data.saturated);
        end else begin
          want = expected_mono.pop_front();
          if (out_data.mono_out !== want.mono_out) begin
            mismatches++;
            $display("%0t: mono_out expected %h actual %h",
                     $time, want.mono_out, out_data.mono_out);
          end
          if (out_data.saturated !== want.saturated) begin
            mismatches++;
            $display("%0t: saturated expected %b actual %b",
                     $time, want.saturated, out_data.saturated);
          end
        end
      end
    end
    outstanding <= expected_mono.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the filter bank testbench: clock, reset, stimulus, back-pressure and verdict.
module tb_top;
  import pbfb_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int mismatches;
  int outstanding;
  // Idle odds: 0 disables, otherwise a burst starts with chance 1/(odds+1) per beat/cycle.
  int gap_odds = 0;
  int stall_odds = 0;
  int stall_left = 0;

  parallel_biquad_filter_bank_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  filter_bank_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: drop ready for bursts of random length.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_odds > 0 && $urandom_range(0, stall_odds) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one beat and hold it until accepted; then maybe drop valid for a short gap.
  // Unless a gap is taken, valid stays high on return so a following beat goes out back to back.
  task automatic send_beat(input in_item_t b);
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    if (gap_odds > 0 && $urandom_range(0, gap_odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every predicted result is back, then idle for tail cycles.
  // The extra edge first lets the checker's count catch up with the last accepted beat.
  task automatic drain(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Register write; a trailing edge with the enable low keeps back-to-back writes clean.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Unused fields carry random bits so every input bit toggles on every beat kind.
  function automatic in_item_t coef_beat(int sec, int sel, logic [31:0] val);
    in_item_t b;
    b.action             = ACT_COEF;
    b.left_sample        = 24'($urandom);
    b.right_sample       = 24'($urandom);
    b.section_index      = sec[3:0];
    b.coefficient_select = sel[2:0];
    b.coefficient_value  = val;
    return b;
  endfunction

  function automatic in_item_t sample_beat(logic [23:0] l, logic [23:0] r);
    in_item_t b;
    b.action             = ACT_SAMPLE;
    b.left_sample        = l;
    b.right_sample       = r;
    b.section_index      = 4'($urandom);
    b.coefficient_select = 3'($urandom);
    b.coefficient_value  = $urandom;
    return b;
  endfunction

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'($urandom_range(0, 512)) - 24'd256;
      default: return 24'($urandom);
    endcase
  endfunction

  // Tame words stay within +/-0.25 so the bank stays stable and off the rails;
  // wild words hit the full-scale corners and drive sections into saturation.
  function automatic logic [31:0] pick_coef(input bit tame);
    if (tame) return 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'h1000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] phase_gain [8];
    bit          tame;
    int          pause_at;

    phase_gain = '{32'h1000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                   32'h0000_0000, 32'h0000_0000, 32'hF000_0000, 32'h0000_0000};
    phase_gain[4] = 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
    phase_gain[5] = $urandom;
    phase_gain[7] = $urandom;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: unity gain, bank still off, so the first sample must vanish.
    write_reg(REG_DIRECT_GAIN, 32'h1000_0000);
    write_reg(REG_BANK_ENABLE, 32'd0);
    send_beat(sample_beat(24'h7FFFFF, 24'h7FFFFF));

    // Load a few sections; select codes past a2 must be dropped by the block.
    send_beat(coef_beat(0, SEL_B0, 32'h1000_0000));
    send_beat(coef_beat(0, 5, 32'h7FFF_FFFF));
    send_beat(coef_beat(7, 7, 32'h8000_0000));
    send_beat(coef_beat(1, SEL_B1, 32'h0800_0000));
    send_beat(coef_beat(2, SEL_B2, 32'hF800_0000));
    send_beat(coef_beat(15, SEL_A1, 32'h7FFF_FFFF));
    send_beat(coef_beat(15, SEL_A2, 32'h8000_0000));
    // Section 4 runs away (gain 8, feedback -(-8)): its output pins at the 32-bit rail.
    send_beat(coef_beat(4, SEL_B0, 32'h7FFF_FFFF));
    send_beat(coef_beat(4, SEL_A1, 32'h8000_0000));
    drain(100);
    write_reg(REG_BANK_ENABLE, 32'd1);

    // Corner pairs, including odd sums whose halving must floor.
    send_beat(sample_beat(24'h000000, 24'h000000));
    send_beat(sample_beat(24'h7FFFFF, 24'h7FFFFF));
    send_beat(sample_beat(24'h800000, 24'h800000));
    send_beat(sample_beat(24'h7FFFFF, 24'h800000));
    send_beat(sample_beat(24'h800000, 24'h7FFFFF));
    send_beat(sample_beat(24'hFFFFFF, 24'h000000));
    send_beat(sample_beat(24'h000001, 24'h000000));
    // Coefficient update while running leaves every history untouched.
    send_beat(coef_beat(4, SEL_A1, 32'h0000_0000));
    send_beat(sample_beat(24'h7FFFFF, 24'h7FFFFF));
    send_beat(sample_beat(24'h123456, 24'hABCDEF));

    // Random phases: each picks a gain, an enable and an idle profile.
    for (int p = 0; p < 8; p++) begin
      drain(100);
      if (p == 7) begin
        // Closing stretch runs flat out on both sides.
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = (p % 3 == 0) ? 0 : $urandom_range(2, 8);
        stall_odds = (p % 3 == 1) ? 0 : $urandom_range(2, 8);
      end
      write_reg(REG_DIRECT_GAIN, phase_gain[p]);
      write_reg(REG_BANK_ENABLE, (p == 2) ? 32'd0 : 32'd1);
      tame = (p % 2 == 0);

      // Tame phases reload the whole bank so no wild leftovers remain.
      if (tame) begin
        for (int s = 0; s < SECTIONS; s++)
          for (int k = 0; k < 5; k++)
            send_beat(coef_beat(s, k, pick_coef(1'b1)));
      end else begin
        repeat (24) send_beat(coef_beat($urandom_range(0, 15), $urandom_range(0, 7),
                                        pick_coef(1'b0)));
      end

      pause_at = $urandom_range(20, 140);
      for (int n = 0; n < 155; n++) begin
        if (n == pause_at) drain(0);
        if ($urandom_range(0, 9) == 0)
          send_beat(coef_beat($urandom_range(0, 15), $urandom_range(0, 7), pick_coef(tame)));
        else
          send_beat(sample_beat(pick_sample(), pick_sample()));
      end
    end

    drain(150);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
